@@ hw/rtl/qsu_pkg.sv @@
// Package for the quoted string unescaper: types, byte codes and state records.
package qsu_pkg;

  typedef enum logic [1:0] {
    PHASE_TEXT   = 2'd0,
    PHASE_ESC    = 2'd1,
    PHASE_HEX_HI = 2'd2,
    PHASE_HEX_LO = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ESCAPE = 2'd1,
    ERR_HEX    = 2'd2
  } err_e;

  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrDQuote    = 8'h22;
  localparam logic [7:0] ChrSQuote    = 8'h27;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrLowA      = 8'h61;
  localparam logic [7:0] ChrLowB      = 8'h62;
  localparam logic [7:0] ChrLowF      = 8'h66;
  localparam logic [7:0] ChrLowN      = 8'h6E;
  localparam logic [7:0] ChrLowR      = 8'h72;
  localparam logic [7:0] ChrLowT      = 8'h74;
  localparam logic [7:0] ChrLowV      = 8'h76;
  localparam logic [7:0] ChrLowX      = 8'h78;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] cont_left;
    logic [3:0] hex_hi;
    logic       hex_err;
  } state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    err_e       error_code;
  } result_t;

endpackage

@@ hw/rtl/quoted_string_unescaper_core.sv @@
// Top level of the quoted string unescaper: input register, decode, result register.
//
// Takes one byte of a quoted string body per transfer and gives at most one decoded
// result per byte. The block is a two-stage pipeline: an input register and a result
// register with the byte decode between them, so it sustains one byte per cycle while
// the output is not stalled by out_ready_i. A backslash, the x of a hex escape and
// the first hex digit give no result; every other byte gives exactly one.
// The closing double quote gives a result with string_end set and byte_valid clear.
module quoted_string_unescaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       string_end_o,
  output logic [1:0] error_code_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  qsu_pkg::state_t  state_q, state_d;
  qsu_pkg::result_t res_d, res_q;
  logic             out_valid_q;
  logic             advance;

  qsu_decode u_decode (
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // advance the held byte when its result (if any) has room
  assign advance    = in_valid_q && (!res_d.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q.phase     <= qsu_pkg::PHASE_TEXT;
      state_q.cont_left <= 2'd0;
      state_q.hex_hi    <= 4'd0;
      state_q.hex_err   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && res_d.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (advance && res_d.emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = res_q.out_byte;
  assign byte_valid_o = res_q.byte_valid;
  assign string_end_o = res_q.string_end;
  assign error_code_o = res_q.error_code;

endmodule

@@ hw/rtl/qsu_decode.sv @@
// Combinational decode of one byte against the parse state.
module qsu_decode (
  input  logic [7:0]      byte_i,
  input  qsu_pkg::state_t state_i,
  output qsu_pkg::state_t state_o,
  output qsu_pkg::result_t result_o
);

  logic [3:0] hex_val;
  logic       hex_bad;
  logic [1:0] follow;

  always_comb begin
    hex_bad = 1'b0;
    hex_val = 4'd0;
    if (byte_i inside {[8'h30:8'h39]}) begin
      hex_val = byte_i[3:0];
    end else if (byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = byte_i[3:0] + 4'd9;
    end else begin
      hex_bad = 1'b1;
    end
  end

  always_comb begin
    if (byte_i inside {[8'hC0:8'hDF]}) begin
      follow = 2'd1;
    end else if (byte_i inside {[8'hE0:8'hEF]}) begin
      follow = 2'd2;
    end else if (byte_i inside {[8'hF0:8'hFD]}) begin
      follow = 2'd3;
    end else begin
      follow = 2'd0;
    end
  end

  always_comb begin
    state_o             = state_i;
    result_o.emit       = 1'b1;
    result_o.out_byte   = byte_i;
    result_o.byte_valid = 1'b1;
    result_o.string_end = 1'b0;
    result_o.error_code = qsu_pkg::ERR_NONE;
    case (state_i.phase)
      qsu_pkg::PHASE_ESC: begin
        state_o.phase = qsu_pkg::PHASE_TEXT;
        case (byte_i)
          qsu_pkg::ChrZero:      result_o.out_byte = 8'h00;
          qsu_pkg::ChrLowA:      result_o.out_byte = 8'h07;
          qsu_pkg::ChrLowB:      result_o.out_byte = 8'h08;
          qsu_pkg::ChrLowF:      result_o.out_byte = 8'h0C;
          qsu_pkg::ChrLowN:      result_o.out_byte = 8'h0A;
          qsu_pkg::ChrLowR:      result_o.out_byte = 8'h0D;
          qsu_pkg::ChrLowT:      result_o.out_byte = 8'h09;
          qsu_pkg::ChrLowV:      result_o.out_byte = 8'h0B;
          qsu_pkg::ChrBackslash: result_o.out_byte = qsu_pkg::ChrBackslash;
          qsu_pkg::ChrSQuote:    result_o.out_byte = qsu_pkg::ChrSQuote;
          qsu_pkg::ChrDQuote:    result_o.out_byte = qsu_pkg::ChrDQuote;
          qsu_pkg::ChrLowX: begin
            state_o.phase = qsu_pkg::PHASE_HEX_HI;
            result_o.emit = 1'b0;
          end
          default: begin
            result_o.out_byte   = 8'h00;
            result_o.error_code = qsu_pkg::ERR_ESCAPE;
          end
        endcase
      end
      qsu_pkg::PHASE_HEX_HI: begin
        state_o.phase   = qsu_pkg::PHASE_HEX_LO;
        state_o.hex_hi  = hex_val;
        state_o.hex_err = hex_bad;
        result_o.emit   = 1'b0;
      end
      qsu_pkg::PHASE_HEX_LO: begin
        state_o.phase     = qsu_pkg::PHASE_TEXT;
        state_o.hex_hi    = 4'd0;
        state_o.hex_err   = 1'b0;
        result_o.out_byte = {state_i.hex_hi, hex_val};
        if (hex_bad || state_i.hex_err) begin
          result_o.error_code = qsu_pkg::ERR_HEX;
        end
      end
      default: begin
        if (state_i.cont_left != 2'd0) begin
          state_o.cont_left = state_i.cont_left - 2'd1;
        end else if (byte_i == qsu_pkg::ChrBackslash) begin
          state_o.phase = qsu_pkg::PHASE_ESC;
          result_o.emit = 1'b0;
        end else if (byte_i == qsu_pkg::ChrDQuote) begin
          result_o.out_byte   = 8'h00;
          result_o.byte_valid = 1'b0;
          result_o.string_end = 1'b1;
        end else begin
          state_o.cont_left = follow;
        end
      end
    endcase
  end

endmodule
